### hdl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam int THREADS  = 16;
   localparam int LEVELS   = 4;
   localparam int THREAD_W = $clog2(THREADS);
   localparam int LEVEL_W  = $clog2(LEVELS);
   localparam int DEFAULT_LEVEL = (LEVELS - 1) < 2 ? (LEVELS - 1) : 2;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   // request codes
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_REMOVE  = 2'd1;
   localparam logic [1:0] REQ_PICK    = 2'd2;
   localparam logic [1:0] REQ_TICK    = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_IGNORED   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_QUANTUM0 = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_QUANTUM1 = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_QUANTUM2 = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_QUANTUM3 = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_AGE_WAIT = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_AGE_PER  = 3'd5;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] thread_id;
      logic [1:0] initial_priority;
      logic       current_running;
   } req_item_type;

   typedef struct packed {
      logic [3:0] picked_thread;
      logic       switched;
      logic [1:0] picked_priority;
      logic [1:0] status;
   } rsp_item_type;

   typedef struct packed {
      logic done;
      logic zero;
   } mod_res_type;

endpackage

### hdl/mlfq_mod_unit.sv
// ----------------------------------------------------------------------------
// mlfq_mod_unit
// Bit-serial restoring remainder, 32-bit dividend by 16-bit divisor.
// ----------------------------------------------------------------------------
module mlfq_mod_unit import mlfq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output mod_res_type res
);

   logic        run_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] quo_ff;
   logic [15:0] rem_ff;
   logic [15:0] div_ff;
   logic        done_ff;
   logic        zero_ff;
   logic [16:0] shifted;
   logic [15:0] rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = 16'(shifted - {1'b0, div_ff});
      end else begin
         rem_in = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            quo_ff <= dividend;
            rem_ff <= '0;
            div_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[30:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               zero_ff <= (rem_in == 16'd0);
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.zero = zero_ff;

endmodule

### hdl/mlfq_thread_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_thread_scheduler
// Four-level feedback queue thread scheduler, lists linked per thread.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   start, busy, req_item         taken when start & !busy
//  response  rsp_valid, rsp_item           one-cycle strobe, cannot stall
//  config    csr_we, csr_addr, csr_wdata   written when csr_we
//
// A remove walks its level's list up to the thread. A tick waits for the
// remainder of the new tick count by the aging period; if it is zero, an
// aging pass walks levels one to three and moves each thread that has waited
// long enough up one level. The running thread is then charged. With aging
// period zero a tick skips the remainder and aging and only charges. Reset
// clears the state, tick, current, registers and table but links and stamps.
// The responder cannot stall: each item gives one strobe then busy drops.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler import mlfq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_PUT        = 4'd2;
   localparam logic [3:0] S_UNLINK     = 4'd3;
   localparam logic [3:0] S_PICK       = 4'd4;
   localparam logic [3:0] S_LEVEL      = 4'd5;
   localparam logic [3:0] S_MODWAIT    = 4'd6;
   localparam logic [3:0] S_AGE_LOAD   = 4'd7;
   localparam logic [3:0] S_AGE        = 4'd8;
   localparam logic [3:0] S_AGE_APPEND = 4'd9;
   localparam logic [3:0] S_CHARGE     = 4'd10;
   localparam logic [3:0] S_DONE       = 4'd11;

   localparam logic [LEVEL_W-1:0] LAST_LVL = LEVEL_W'(LEVELS - 1);

   // per-thread table
   logic [THREAD_W-1:0] link_ff   [THREADS];
   logic [LEVEL_W-1:0]  level_ff  [THREADS];
   logic [15:0]         est_ff    [THREADS];
   logic [15:0]         run_ff    [THREADS];
   logic [31:0]         stamp_ff  [THREADS];
   logic                queued_ff [THREADS];
   logic                known_ff  [THREADS];
   logic [THREAD_W-1:0] head_ff   [LEVELS];
   logic [THREAD_W-1:0] tail_ff   [LEVELS];
   logic [THREAD_W-1:0] current_ff;
   logic [31:0]         tick_ff;

   // registers
   logic [15:0] quantum_ff [LEVELS];
   logic [15:0] age_wait_ff;
   logic [15:0] age_per_ff;

   // sequencer
   logic [3:0]          state_ff, state_in;
   req_item_type        req_ff;
   logic [THREAD_W-1:0] put_t_ff;
   logic [LEVEL_W-1:0]  put_lvl_ff;
   logic                put_pick_ff;
   logic [LEVEL_W-1:0]  walk_lvl_ff;
   logic [THREAD_W-1:0] walk_prev_ff;
   logic [THREAD_W-1:0] walk_cur_ff;
   logic [THREAD_W-1:0] pick_t_ff;
   logic [16:0]         est_tmp_ff;
   logic                switched_ff;
   logic [1:0]          status_ff;

   logic [THREAD_W-1:0] tid;
   logic [31:0]         tick_next;
   logic                mod_go;
   mod_res_type         mod_res;
   logic                any_ready;
   logic [LEVEL_W-1:0]  pick_lvl;
   logic [LEVEL_W-1:0]  new_lvl;
   logic [LEVEL_W-1:0]  enq_lvl;
   logic [15:0]         run_sat;
   logic [LEVEL_W-1:0]  age_dst;
   logic                aged;

   assign tid       = THREAD_W'(req_ff.thread_id);
   assign tick_next = tick_ff + 32'd1;
   assign mod_go    = (state_ff == S_DISPATCH) && (req_ff.req_type == REQ_TICK)
                      && (age_per_ff != 16'd0);
   assign age_dst   = walk_lvl_ff - LEVEL_W'(1);
   assign aged      = (tick_ff - stamp_ff[walk_cur_ff]) >= {16'd0, age_wait_ff};

   // highest non-empty level
   always_comb begin
      any_ready = 1'b0;
      pick_lvl  = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] != '0) begin
            any_ready = 1'b1;
            pick_lvl  = LEVEL_W'(i);
         end
      end
   end

   // first level whose quantum covers the estimate
   always_comb begin
      new_lvl = LAST_LVL;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (est_tmp_ff <= {1'b0, quantum_ff[i]}) begin
            new_lvl = LEVEL_W'(i);
         end
      end
   end

   always_comb begin
      if (known_ff[tid]) begin
         enq_lvl = level_ff[tid];
      end else if (32'(req_ff.initial_priority) < LEVELS) begin
         enq_lvl = LEVEL_W'(req_ff.initial_priority);
      end else begin
         enq_lvl = LEVEL_W'(DEFAULT_LEVEL);
      end
   end

   assign run_sat = (run_ff[current_ff] == 16'hFFFF) ? 16'hFFFF
                                                      : run_ff[current_ff] + 16'd1;

   mlfq_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .go       (mod_go),
      .dividend (tick_next),
      .divisor  (age_per_ff),
      .res      (mod_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (req_ff.req_type)
               REQ_ENQUEUE: begin
                  if (tid == '0 || queued_ff[tid]) state_in = S_DONE;
                  else state_in = S_PUT;
               end
               REQ_REMOVE: begin
                  if (tid == '0 || !queued_ff[tid]) state_in = S_DONE;
                  else state_in = S_UNLINK;
               end
               REQ_PICK: state_in = S_PICK;
               REQ_TICK: begin
                  if (age_per_ff != 16'd0) state_in = S_MODWAIT;
                  else state_in = S_CHARGE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PUT: state_in = put_pick_ff ? S_PICK : S_DONE;
         S_UNLINK: begin
            if (walk_cur_ff == '0 || walk_cur_ff == tid) state_in = S_DONE;
         end
         S_PICK: state_in = any_ready ? S_LEVEL : S_DONE;
         S_LEVEL: state_in = S_DONE;
         S_MODWAIT: begin
            if (mod_res.done) state_in = mod_res.zero ? S_AGE_LOAD : S_CHARGE;
         end
         S_AGE_LOAD: state_in = S_AGE;
         S_AGE: begin
            if (walk_cur_ff == '0) begin
               state_in = (walk_lvl_ff == LAST_LVL) ? S_CHARGE : S_AGE_LOAD;
            end else if (aged) begin
               state_in = S_AGE_APPEND;
            end
         end
         S_AGE_APPEND: state_in = S_AGE;
         S_CHARGE: begin
            if (!req_ff.current_running) begin
               state_in = S_DONE;
            end else if (current_ff == '0) begin
               state_in = S_PICK;
            end else if (run_sat >= quantum_ff[level_ff[current_ff]]) begin
               state_in = queued_ff[current_ff] ? S_PICK : S_PUT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         current_ff  <= '0;
         tick_ff     <= '0;
         switched_ff <= 1'b0;
         status_ff   <= ST_DONE;
         put_pick_ff <= 1'b0;
         for (int i = 0; i < THREADS; i++) begin
            level_ff[i]  <= '0;
            est_ff[i]    <= '0;
            run_ff[i]    <= '0;
            queued_ff[i] <= 1'b0;
            known_ff[i]  <= 1'b0;
         end
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
         end
         quantum_ff[0] <= 16'd40;
         quantum_ff[1] <= 16'd80;
         if (LEVELS > 2) quantum_ff[LEVELS > 2 ? 2 : 0] <= 16'd120;
         if (LEVELS > 3) quantum_ff[LEVELS > 3 ? 3 : 0] <= 16'd200;
         age_wait_ff <= 16'd50;
         age_per_ff  <= 16'd100;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               CSR_QUANTUM0, CSR_QUANTUM1, CSR_QUANTUM2, CSR_QUANTUM3: begin
                  if (32'(csr_addr) < LEVELS) begin
                     quantum_ff[LEVEL_W'(csr_addr)] <= csr_wdata;
                  end
               end
               CSR_AGE_WAIT: age_wait_ff <= csr_wdata;
               CSR_AGE_PER:  age_per_ff  <= csr_wdata;
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff      <= req_item;
                  switched_ff <= 1'b0;
                  status_ff   <= ST_DONE;
               end
            end
            S_DISPATCH: begin
               put_pick_ff <= 1'b0;
               unique case (req_ff.req_type)
                  REQ_ENQUEUE: begin
                     if (tid == '0 || queued_ff[tid]) begin
                        status_ff <= ST_IGNORED;
                     end else begin
                        put_t_ff   <= tid;
                        put_lvl_ff <= enq_lvl;
                        if (!known_ff[tid]) run_ff[tid] <= '0;
                     end
                  end
                  REQ_REMOVE: begin
                     if (tid == '0) begin
                        status_ff <= ST_IGNORED;
                     end else begin
                        if (!queued_ff[tid]) status_ff <= ST_NOT_FOUND;
                        walk_lvl_ff  <= level_ff[tid];
                        walk_prev_ff <= '0;
                        walk_cur_ff  <= head_ff[level_ff[tid]];
                        queued_ff[tid] <= 1'b0;
                        known_ff[tid]  <= 1'b0;
                     end
                  end
                  REQ_PICK: switched_ff <= 1'b1;
                  REQ_TICK: begin
                     tick_ff     <= tick_next;
                     walk_lvl_ff <= LEVEL_W'(1);
                  end
                  default: ;
               endcase
            end
            S_PUT: begin
               // append put_t at the tail of put_lvl
               level_ff[put_t_ff]  <= put_lvl_ff;
               link_ff[put_t_ff]   <= '0;
               if (head_ff[put_lvl_ff] == '0) head_ff[put_lvl_ff] <= put_t_ff;
               else link_ff[tail_ff[put_lvl_ff]] <= put_t_ff;
               tail_ff[put_lvl_ff]   <= put_t_ff;
               est_ff[put_t_ff]      <= quantum_ff[put_lvl_ff];
               stamp_ff[put_t_ff]    <= tick_ff;
               queued_ff[put_t_ff]   <= 1'b1;
               known_ff[put_t_ff]    <= 1'b1;
            end
            S_UNLINK: begin
               if (walk_cur_ff == '0) begin
                  status_ff <= ST_NOT_FOUND;
               end else if (walk_cur_ff == tid) begin
                  if (walk_prev_ff == '0) head_ff[walk_lvl_ff] <= link_ff[walk_cur_ff];
                  else link_ff[walk_prev_ff] <= link_ff[walk_cur_ff];
                  if (tail_ff[walk_lvl_ff] == tid) tail_ff[walk_lvl_ff] <= walk_prev_ff;
               end else begin
                  walk_prev_ff <= walk_cur_ff;
                  walk_cur_ff  <= link_ff[walk_cur_ff];
               end
            end
            S_PICK: begin
               switched_ff <= 1'b1;
               if (any_ready) begin
                  pick_t_ff <= head_ff[pick_lvl];
                  head_ff[pick_lvl] <= link_ff[head_ff[pick_lvl]];
                  if (link_ff[head_ff[pick_lvl]] == '0) tail_ff[pick_lvl] <= '0;
                  queued_ff[head_ff[pick_lvl]] <= 1'b0;
                  est_tmp_ff <= ({1'b0, run_ff[head_ff[pick_lvl]]}
                                 + {1'b0, est_ff[head_ff[pick_lvl]]}) >> 1;
                  run_ff[head_ff[pick_lvl]] <= '0;
                  current_ff <= head_ff[pick_lvl];
               end else begin
                  current_ff <= '0;
               end
            end
            S_LEVEL: begin
               est_ff[pick_t_ff]   <= est_tmp_ff[15:0];
               level_ff[pick_t_ff] <= new_lvl;
            end
            S_MODWAIT: ;
            S_AGE_LOAD: begin
               walk_prev_ff <= '0;
               walk_cur_ff  <= head_ff[walk_lvl_ff];
            end
            S_AGE: begin
               if (walk_cur_ff == '0) begin
                  if (walk_lvl_ff != LAST_LVL) walk_lvl_ff <= walk_lvl_ff + LEVEL_W'(1);
               end else begin
                  walk_cur_ff <= link_ff[walk_cur_ff];
                  if (aged) begin
                     // unlink here, append one level up next cycle
                     put_t_ff <= walk_cur_ff;
                     if (walk_prev_ff == '0) head_ff[walk_lvl_ff] <= link_ff[walk_cur_ff];
                     else link_ff[walk_prev_ff] <= link_ff[walk_cur_ff];
                     if (tail_ff[walk_lvl_ff] == walk_cur_ff) begin
                        tail_ff[walk_lvl_ff] <= walk_prev_ff;
                     end
                  end else begin
                     walk_prev_ff <= walk_cur_ff;
                  end
               end
            end
            S_AGE_APPEND: begin
               level_ff[put_t_ff] <= age_dst;
               stamp_ff[put_t_ff] <= tick_ff;
               link_ff[put_t_ff]  <= '0;
               if (head_ff[age_dst] == '0) head_ff[age_dst] <= put_t_ff;
               else link_ff[tail_ff[age_dst]] <= put_t_ff;
               tail_ff[age_dst] <= put_t_ff;
            end
            S_CHARGE: begin
               if (req_ff.current_running && current_ff != '0) begin
                  run_ff[current_ff] <= run_sat;
                  put_t_ff    <= current_ff;
                  put_lvl_ff  <= level_ff[current_ff];
                  put_pick_ff <= 1'b1;
               end
            end
            S_DONE: ;
            default: ;
         endcase
      end
   end

   assign busy                     = (state_ff != S_IDLE);
   assign rsp_valid                = (state_ff == S_DONE);
   assign rsp_item.picked_thread   = 4'(current_ff);
   assign rsp_item.switched        = switched_ff;
   assign rsp_item.picked_priority = 2'(level_ff[current_ff]);
   assign rsp_item.status          = status_ff;

endmodule

### hdl/mlfq_checker.sv
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks of the scheduler's command and response timing.
// ----------------------------------------------------------------------------
module mlfq_checker import mlfq_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");

   // a response only ends a busy period
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

   // the response is a single strobe and frees the block
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid)) else $error("response not final");

   // the idle thread always reports the top level
   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.picked_thread == 4'd0) |-> rsp_item.picked_priority == 2'd0)
      else $error("idle thread with nonzero level");

endmodule

bind mlfq_thread_scheduler mlfq_checker u_mlfq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
